>>> hdl/fpc_pkg.sv
package fpc_pkg;

  // default stored coefficient width
  localparam int DATA_WIDTH_DEF = 32;

  // width of the value fields on the request port
  localparam int IN_W = 32;

  // fractional bits of the fixed point format
  localparam int FRAC_BITS = 16;

  // clip planes: left, right, bottom, top, near, far
  localparam int NUM_PLANES = 6;

  // request codes
  typedef enum logic [1:0] {
    REQ_LOAD_VIEW = 2'd0,
    REQ_LOAD_PROJ = 2'd1,
    REQ_REBUILD   = 2'd2,
    REQ_TEST      = 2'd3
  } req_code_t;

endpackage

>>> hdl/frustum_point_culling.sv
// channel   | handshake              | payload
// ----------+------------------------+-------------------------------------------
// request   | req_valid / req_stall  | req_type, row_index, val0, val1, val2, val3
// result    | res_valid / res_stall  | inside_res (test requests only)
//
// Load requests complete in the cycle they are accepted. A rebuild runs 4 matrix
// rows, each of 16 products, a drain step and 6 plane updates. A test runs 24
// plane-point products, a drain step and a delivery. All products go through
// one shared registered multiplier. Reset clears both matrices and all planes
// to zero. A held result does not block new requests; a test that finishes
// while the previous result is still stalled waits until the output register
// frees up.
module frustum_point_culling #(
  parameter int DATA_WIDTH = fpc_pkg::DATA_WIDTH_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      req_valid,
  output logic                      req_stall,
  input  fpc_pkg::req_code_t        req_type,
  input  logic [1:0]                row_index,
  input  logic signed [fpc_pkg::IN_W-1:0] val0,
  input  logic signed [fpc_pkg::IN_W-1:0] val1,
  input  logic signed [fpc_pkg::IN_W-1:0] val2,
  input  logic signed [fpc_pkg::IN_W-1:0] val3,
  output logic                      res_valid,
  input  logic                      res_stall,
  output logic                      inside_res
);
  import fpc_pkg::*;

  localparam int MUL_B_W = (DATA_WIDTH > IN_W) ? DATA_WIDTH : IN_W;
  localparam int PROD_W  = DATA_WIDTH + MUL_B_W;
  localparam int ACC_W   = PROD_W + 2;

  localparam logic signed [ACC_W-1:0] SAT_MAX =
    {{(ACC_W-DATA_WIDTH+1){1'b0}}, {(DATA_WIDTH-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] SAT_MIN = ~SAT_MAX;
  localparam logic signed [MUL_B_W-1:0] ONE_Q =
    {{(MUL_B_W-FRAC_BITS-1){1'b0}}, 1'b1, {FRAC_BITS{1'b0}}};
  localparam logic [2:0] LAST_PLANE = 3'(NUM_PLANES - 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MAC,
    ST_DRAIN,
    ST_PLANE,
    ST_TEST,
    ST_TDRAIN,
    ST_FIN
  } state_t;

  // clamp a wide signed value into the stored width
  function automatic logic signed [DATA_WIDTH-1:0] sat_dw(input logic signed [ACC_W-1:0] v);
    logic signed [ACC_W-1:0] c;
    c = v;
    if (v > SAT_MAX) c = SAT_MAX;
    if (v < SAT_MIN) c = SAT_MIN;
    return c[DATA_WIDTH-1:0];
  endfunction

  state_t state;

  // matrices and planes
  logic signed [DATA_WIDTH-1:0] view_m  [0:3][0:3];
  logic signed [DATA_WIDTH-1:0] proj_m  [0:3][0:3];
  logic signed [DATA_WIDTH-1:0] plane_m [0:NUM_PLANES-1][0:3];

  // one row of the combined matrix, rebuilt row by row
  logic signed [DATA_WIDTH-1:0] vp_row [0:3];

  // latched test point
  logic signed [MUL_B_W-1:0] pt [0:2];

  // sequencer counters
  logic [1:0] cnt_k;
  logic [1:0] cnt_j;
  logic [1:0] row_i;
  logic [2:0] pl;

  // multiplier stage
  logic signed [DATA_WIDTH-1:0] mul_a;
  logic signed [MUL_B_W-1:0]    mul_b;
  logic                         issue;
  logic signed [PROD_W-1:0]     prod;
  logic                         prod_v;
  logic                         prod_first;
  logic                         prod_last;
  logic                         prod_test;
  logic [1:0]                   prod_tag;

  // accumulator stage
  logic signed [ACC_W-1:0] acc;
  logic signed [ACC_W-1:0] acc_next;
  logic signed [ACC_W-1:0] vp_shift;
  logic                    inside_flag;

  // plane add
  logic signed [DATA_WIDTH+1:0] pl_base;
  logic signed [DATA_WIDTH+1:0] pl_other;
  logic signed [DATA_WIDTH+1:0] pl_sum;

  // load values and accept
  logic signed [IN_W-1:0] val_in [0:3];
  logic                   req_acc;

  assign req_stall = (state != ST_IDLE);
  assign req_acc   = req_valid && !req_stall;

  always_comb begin
    val_in[0] = val0;
    val_in[1] = val1;
    val_in[2] = val2;
    val_in[3] = val3;
  end

  // operand select for the shared multiplier
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    issue = 1'b0;
    case (state)
      ST_MAC: begin
        mul_a = view_m[row_i][cnt_k];
        mul_b = MUL_B_W'(proj_m[cnt_k][cnt_j]);
        issue = 1'b1;
      end
      ST_TEST: begin
        mul_a = plane_m[pl][cnt_k];
        mul_b = (cnt_k == 2'd3) ? ONE_Q : pt[cnt_k];
        issue = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // running sum of products
  always_comb begin
    acc_next = prod_first ? ACC_W'(prod) : acc + ACC_W'(prod);
    vp_shift = acc_next >>> FRAC_BITS;
  end

  // plane coefficient: column 4 plus or minus the selected column
  always_comb begin
    pl_base  = (DATA_WIDTH+2)'(vp_row[3]);
    pl_other = (DATA_WIDTH+2)'(vp_row[pl[2:1]]);
    pl_sum   = pl[0] ? pl_base - pl_other : pl_base + pl_other;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      res_valid <= 1'b0;
      prod_v    <= 1'b0;
      cnt_k     <= 2'd0;
      cnt_j     <= 2'd0;
      row_i     <= 2'd0;
      pl        <= 3'd0;
      for (int r = 0; r < 4; r++) begin
        for (int c = 0; c < 4; c++) begin
          view_m[r][c] <= '0;
          proj_m[r][c] <= '0;
        end
      end
      for (int p = 0; p < NUM_PLANES; p++) begin
        for (int c = 0; c < 4; c++) begin
          plane_m[p][c] <= '0;
        end
      end
    end else begin
      // multiplier register
      prod       <= mul_a * mul_b;
      prod_v     <= issue;
      prod_first <= (cnt_k == 2'd0);
      prod_last  <= (cnt_k == 2'd3);
      prod_test  <= (state == ST_TEST);
      prod_tag   <= cnt_j;

      // accumulate and finish a dot product
      if (prod_v) begin
        acc <= acc_next;
        if (prod_last) begin
          if (prod_test) begin
            inside_flag <= inside_flag & ~acc_next[ACC_W-1];
          end else begin
            vp_row[prod_tag] <= sat_dw(vp_shift);
          end
        end
      end

      // result register drains independently
      if (res_valid && !res_stall && state != ST_FIN) begin
        res_valid <= 1'b0;
      end

      case (state)
        ST_IDLE: begin
          if (req_acc) begin
            cnt_k <= 2'd0;
            cnt_j <= 2'd0;
            row_i <= 2'd0;
            pl    <= 3'd0;
            case (req_type)
              REQ_LOAD_VIEW: begin
                for (int c = 0; c < 4; c++) begin
                  view_m[row_index][c] <= sat_dw(ACC_W'(val_in[c]));
                end
              end
              REQ_LOAD_PROJ: begin
                for (int c = 0; c < 4; c++) begin
                  proj_m[row_index][c] <= sat_dw(ACC_W'(val_in[c]));
                end
              end
              REQ_REBUILD: begin
                state <= ST_MAC;
              end
              REQ_TEST: begin
                pt[0]       <= MUL_B_W'(val0);
                pt[1]       <= MUL_B_W'(val1);
                pt[2]       <= MUL_B_W'(val2);
                inside_flag <= 1'b1;
                state       <= ST_TEST;
              end
              default: begin
              end
            endcase
          end
        end
        ST_MAC: begin
          // k innermost, then column j
          cnt_k <= cnt_k + 2'd1;
          if (cnt_k == 2'd3) begin
            cnt_j <= cnt_j + 2'd1;
            if (cnt_j == 2'd3) begin
              state <= ST_DRAIN;
            end
          end
        end
        ST_DRAIN: begin
          pl    <= 3'd0;
          state <= ST_PLANE;
        end
        ST_PLANE: begin
          plane_m[pl][row_i] <= sat_dw(ACC_W'(pl_sum));
          pl <= pl + 3'd1;
          if (pl == LAST_PLANE) begin
            cnt_k <= 2'd0;
            cnt_j <= 2'd0;
            row_i <= row_i + 2'd1;
            state <= (row_i == 2'd3) ? ST_IDLE : ST_MAC;
          end
        end
        ST_TEST: begin
          // coefficient r innermost, then plane
          cnt_k <= cnt_k + 2'd1;
          if (cnt_k == 2'd3) begin
            pl <= pl + 3'd1;
            if (pl == LAST_PLANE) begin
              state <= ST_TDRAIN;
            end
          end
        end
        ST_TDRAIN: begin
          state <= ST_FIN;
        end
        ST_FIN: begin
          if (!res_valid || !res_stall) begin
            res_valid  <= 1'b1;
            inside_res <= inside_flag;
            state      <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

>>> tb/frustum_point_culling_tb.sv
`timescale 1ns / 100ps

module frustum_point_culling_tb;
  import fpc_pkg::*;

  localparam int DW = DATA_WIDTH_DEF;
  localparam int RANDOM_REQUESTS = 1500;
  localparam int NUM_DIRECTED = 25;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int DRAIN_CYCLES = 120;
  localparam int PREDICT = -1;

  // handy Q16.16 values
  localparam logic signed [IN_W-1:0] ONE  = 32'sh0001_0000;
  localparam logic signed [IN_W-1:0] MONE = 32'shFFFF_0000;
  localparam logic signed [IN_W-1:0] TWO  = 32'sh0002_0000;
  localparam logic signed [IN_W-1:0] PMAX = 32'sh7FFF_FFFF;
  localparam logic signed [IN_W-1:0] NMIN = 32'sh8000_0000;

  typedef struct {
    req_code_t              code;
    logic [1:0]             row;
    logic signed [IN_W-1:0] v0, v1, v2, v3;
    int                     want;
  } stim_row_t;

  typedef struct {
    bit hit;
    int idx;
  } inside_exp_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   req_valid = 1'b0;
  logic                   req_stall;
  req_code_t              req_type = REQ_LOAD_VIEW;
  logic [1:0]             row_index = 2'd0;
  logic signed [IN_W-1:0] val0 = '0;
  logic signed [IN_W-1:0] val1 = '0;
  logic signed [IN_W-1:0] val2 = '0;
  logic signed [IN_W-1:0] val3 = '0;
  logic                   res_valid;
  logic                   res_stall = 1'b0;
  logic                   inside_res;

  // predictor state
  logic signed [DW-1:0] view_m [16];
  logic signed [DW-1:0] proj_m [16];
  logic signed [DW-1:0] planes [24];

  inside_exp_t inside_expected[$];
  inside_exp_t head;

  int  errors = 0;
  int  sent = 0;
  int  n_loads = 0;
  int  n_rebuilds = 0;
  int  n_tests = 0;
  int  n_in = 0;
  int  n_out = 0;
  int  cycle_count = 0;
  bit  calm = 1'b0;

  // directed requests: extremes, identity frustum, stale planes
  stim_row_t directed_rows [NUM_DIRECTED] = '{
    '{REQ_TEST,      2'd3, PMAX, NMIN, PMAX, NMIN, 1},
    '{REQ_TEST,      2'd0, NMIN, PMAX, NMIN, PMAX, 1},
    '{REQ_REBUILD,   2'd0, 0,    0,    0,    0,    PREDICT},
    '{REQ_TEST,      2'd1, 0,    0,    0,    0,    1},
    '{REQ_LOAD_VIEW, 2'd0, ONE,  0,    0,    0,    PREDICT},
    '{REQ_LOAD_VIEW, 2'd1, 0,    ONE,  0,    0,    PREDICT},
    '{REQ_LOAD_VIEW, 2'd2, 0,    0,    ONE,  0,    PREDICT},
    '{REQ_LOAD_VIEW, 2'd3, 0,    0,    0,    ONE,  PREDICT},
    '{REQ_LOAD_PROJ, 2'd0, ONE,  0,    0,    0,    PREDICT},
    '{REQ_LOAD_PROJ, 2'd1, 0,    ONE,  0,    0,    PREDICT},
    '{REQ_LOAD_PROJ, 2'd2, 0,    0,    ONE,  0,    PREDICT},
    '{REQ_LOAD_PROJ, 2'd3, 0,    0,    0,    ONE,  PREDICT},
    '{REQ_TEST,      2'd2, TWO,  0,    0,    NMIN, 1},
    '{REQ_REBUILD,   2'd1, 0,    0,    0,    0,    PREDICT},
    '{REQ_TEST,      2'd0, 0,    0,    0,    PMAX, 1},
    '{REQ_TEST,      2'd0, TWO,  0,    0,    0,    0},
    '{REQ_TEST,      2'd0, ONE,  ONE,  ONE,  0,    1},
    '{REQ_TEST,      2'd0, MONE, MONE, MONE, 0,    1},
    '{REQ_TEST,      2'd0, 0,    0,    NMIN, 0,    0},
    '{REQ_LOAD_VIEW, 2'd0, PMAX, NMIN, PMAX, NMIN, PREDICT},
    '{REQ_LOAD_VIEW, 2'd3, NMIN, NMIN, PMAX, PMAX, PREDICT},
    '{REQ_LOAD_PROJ, 2'd2, PMAX, PMAX, NMIN, NMIN, PREDICT},
    '{REQ_REBUILD,   2'd3, PMAX, NMIN, PMAX, NMIN, PREDICT},
    '{REQ_TEST,      2'd1, PMAX, NMIN, ONE,  0,    PREDICT},
    '{REQ_TEST,      2'd0, 0,    0,    0,    0,    PREDICT}
  };

  frustum_point_culling DUT (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req_valid),
    .req_stall  (req_stall),
    .req_type   (req_type),
    .row_index  (row_index),
    .val0       (val0),
    .val1       (val1),
    .val2       (val2),
    .val3       (val3),
    .res_valid  (res_valid),
    .res_stall  (res_stall),
    .inside_res (inside_res)
  );

  // clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // cycle limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("frustum_point_culling_tb NOT OK");
      $finish;
    end
  end

  task automatic flag_mismatch(input string msg);
    errors++;
    if (errors <= 40)
      $display("MISMATCH at %0t: %s", $time, msg);
  endtask

  // clamp to the stored coefficient width
  function automatic logic signed [DW-1:0] sat_dw(input logic signed [67:0] v);
    logic signed [67:0] hi;
    logic signed [67:0] lo;
    hi = (68'sd1 <<< (DW - 1)) - 68'sd1;
    lo = -hi - 68'sd1;
    if (v > hi)
      return hi[DW-1:0];
    if (v < lo)
      return lo[DW-1:0];
    return v[DW-1:0];
  endfunction

  // vp = view * proj, then the six clip planes from its columns
  function automatic void rebuild_frustum();
    logic signed [67:0] acc;
    logic signed [67:0] t;
    logic signed [67:0] u;
    logic signed [DW-1:0] vp [16];
    for (int i = 0; i < 4; i++)
      for (int j = 0; j < 4; j++) begin
        acc = 68'sd0;
        for (int k = 0; k < 4; k++)
          acc = acc + 68'(view_m[i*4+k]) * 68'(proj_m[k*4+j]);
        vp[i*4+j] = sat_dw(acc >>> FRAC_BITS);
      end
    for (int p = 0; p < NUM_PLANES; p++)
      for (int r = 0; r < 4; r++) begin
        t = 68'(vp[r*4+3]);
        u = 68'(vp[r*4+p/2]);
        planes[p*4+r] = sat_dw((p % 2 == 1) ? t - u : t + u);
      end
  endfunction

  // exact dot product against every plane, sign test only
  function automatic bit point_in_frustum(input logic signed [IN_W-1:0] x,
                                          input logic signed [IN_W-1:0] y,
                                          input logic signed [IN_W-1:0] z);
    logic signed [67:0] acc;
    logic signed [67:0] px;
    logic signed [67:0] py;
    logic signed [67:0] pz;
    logic signed [67:0] unit;
    px = 68'(x);
    py = 68'(y);
    pz = 68'(z);
    unit = 68'sd1 <<< FRAC_BITS;
    for (int p = 0; p < NUM_PLANES; p++) begin
      acc = 68'(planes[p*4]) * px + 68'(planes[p*4+1]) * py
            + 68'(planes[p*4+2]) * pz + 68'(planes[p*4+3]) * unit;
      if (acc < 0)
        return 1'b0;
    end
    return 1'b1;
  endfunction

  // advance the predictor by one accepted request
  function automatic void culling_step(input stim_row_t rq, input int idx);
    inside_exp_t e;
    case (rq.code)
      REQ_LOAD_VIEW: begin
        view_m[rq.row*4]   = sat_dw(68'(rq.v0));
        view_m[rq.row*4+1] = sat_dw(68'(rq.v1));
        view_m[rq.row*4+2] = sat_dw(68'(rq.v2));
        view_m[rq.row*4+3] = sat_dw(68'(rq.v3));
        n_loads++;
      end
      REQ_LOAD_PROJ: begin
        proj_m[rq.row*4]   = sat_dw(68'(rq.v0));
        proj_m[rq.row*4+1] = sat_dw(68'(rq.v1));
        proj_m[rq.row*4+2] = sat_dw(68'(rq.v2));
        proj_m[rq.row*4+3] = sat_dw(68'(rq.v3));
        n_loads++;
      end
      REQ_REBUILD: begin
        rebuild_frustum();
        n_rebuilds++;
      end
      default: begin
        e.hit = (rq.want == PREDICT) ? point_in_frustum(rq.v0, rq.v1, rq.v2)
                                     : (rq.want != 0);
        e.idx = idx;
        inside_expected.push_back(e);
        n_tests++;
      end
    endcase
  endfunction

  // drive one request at a falling edge, hold it until accepted
  task automatic send_request(input stim_row_t rq);
    req_valid <= 1'b1;
    req_type  <= rq.code;
    row_index <= rq.row;
    val0      <= rq.v0;
    val1      <= rq.v1;
    val2      <= rq.v2;
    val3      <= rq.v3;
    @(posedge clk);
    while (req_stall)
      @(posedge clk);
    culling_step(rq, sent);
    sent++;
    calm = (sent >= 600 && sent < 900);
    @(negedge clk);
  endtask

  task automatic idle_cycles(input int n);
    req_valid <= 1'b0;
    repeat (n) @(negedge clk);
  endtask

  task automatic maybe_gap();
    if (!calm && $urandom_range(0, 99) < 13)
      idle_cycles($urandom_range(1, 4));
  endtask

  task automatic hold_until_drained();
    req_valid <= 1'b0;
    do @(negedge clk); while (inside_expected.size() != 0);
  endtask

  // mostly modest matrices near a diagonal, some full-range noise
  function automatic logic signed [IN_W-1:0] matrix_entry(input bit on_diag);
    if ($urandom_range(0, 9) == 0)
      return $urandom;
    if (on_diag)
      return $urandom_range(16384, 131072);
    return int'($urandom_range(0, 32768)) - 16384;
  endfunction

  function automatic logic signed [IN_W-1:0] point_coord();
    if ($urandom_range(0, 99) < 15)
      return $urandom;
    return int'($urandom_range(0, 196608)) - 98304;
  endfunction

  // result checker
  always @(posedge clk) begin
    if (!rst && res_valid && !res_stall) begin
      if (inside_expected.size() == 0) begin
        flag_mismatch($sformatf("result inside_res=%0b with none pending", inside_res));
      end else begin
        head = inside_expected.pop_front();
        if (inside_res !== head.hit)
          flag_mismatch($sformatf("request %0d: inside_res=%0b, expected %0b",
                                  head.idx, inside_res, head.hit));
        else if (head.hit)
          n_in++;
        else
          n_out++;
      end
    end
  end

  // result side stalls
  always @(negedge clk)
    res_stall <= !rst && !calm && ($urandom_range(0, 99) < 13);

  // stimulus
  initial begin
    stim_row_t rq;
    int        n_scene_loads;
    int        n_scene_tests;

    foreach (view_m[i]) begin
      view_m[i] = '0;
      proj_m[i] = '0;
    end
    foreach (planes[i])
      planes[i] = '0;

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed part
    for (int i = 0; i < NUM_DIRECTED; i++) begin
      maybe_gap();
      send_request(directed_rows[i]);
    end
    hold_until_drained();

    // random scenes: load some rows, usually rebuild, test a batch of points
    while (sent < NUM_DIRECTED + RANDOM_REQUESTS) begin
      n_scene_loads = $urandom_range(0, 8);
      for (int i = 0; i < n_scene_loads; i++) begin
        rq.code = $urandom_range(0, 1) ? REQ_LOAD_PROJ : REQ_LOAD_VIEW;
        rq.row  = 2'($urandom_range(0, 3));
        rq.v0   = matrix_entry(rq.row == 2'd0);
        rq.v1   = matrix_entry(rq.row == 2'd1);
        rq.v2   = matrix_entry(rq.row == 2'd2);
        rq.v3   = matrix_entry(rq.row == 2'd3);
        rq.want = PREDICT;
        maybe_gap();
        send_request(rq);
      end

      if ($urandom_range(0, 9) != 0) begin
        rq.code = REQ_REBUILD;
        rq.row  = 2'($urandom_range(0, 3));
        rq.v0   = $urandom;
        rq.v1   = $urandom;
        rq.v2   = $urandom;
        rq.v3   = $urandom;
        rq.want = PREDICT;
        maybe_gap();
        send_request(rq);
      end

      n_scene_tests = $urandom_range(3, 15);
      for (int i = 0; i < n_scene_tests; i++) begin
        rq.code = REQ_TEST;
        rq.row  = 2'($urandom_range(0, 3));
        rq.v0   = point_coord();
        rq.v1   = point_coord();
        rq.v2   = point_coord();
        rq.v3   = $urandom;
        rq.want = PREDICT;
        maybe_gap();
        send_request(rq);
      end

      // occasional fully random request
      if ($urandom_range(0, 19) == 0) begin
        rq.code = req_code_t'($urandom_range(0, 3));
        rq.row  = 2'($urandom_range(0, 3));
        rq.v0   = $urandom;
        rq.v1   = $urandom;
        rq.v2   = $urandom;
        rq.v3   = $urandom;
        rq.want = PREDICT;
        maybe_gap();
        send_request(rq);
      end

      if ($urandom_range(0, 24) == 0)
        hold_until_drained();
    end

    // drain and let the last rebuild settle
    hold_until_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (inside_expected.size() != 0)
      flag_mismatch($sformatf("%0d results never arrived", inside_expected.size()));

    $display("covered %0d requests: %0d row loads, %0d rebuilds, %0d point tests",
             sent, n_loads, n_rebuilds, n_tests);
    $display("points seen inside: %0d, outside: %0d, mismatches: %0d",
             n_in, n_out, errors);
    if (errors == 0)
      $display("frustum_point_culling_tb OK");
    else
      $display("frustum_point_culling_tb NOT OK");
    $finish;
  end

endmodule

>>> frustum_point_culling.f
hdl/fpc_pkg.sv
hdl/frustum_point_culling.sv
tb/frustum_point_culling_tb.sv
